@@ sv/confusion_matrix_metrics_defines.svh @@
// Assertion macros shared by the confusion-matrix metrics RTL.
// Expects i_clk and active-low i_rst_n in the scope where a macro is used.
`ifndef CONFUSION_MATRIX_METRICS_DEFINES_SVH
`define CONFUSION_MATRIX_METRICS_DEFINES_SVH

// Same-cycle implication.
`define CMM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cmm_pkg.sv @@
// Shared constants and types for the confusion-matrix metrics block.
// No dependencies; used by cmm_mul, cmm_div and confusion_matrix_metrics.
package cmm_pkg;

    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int IN_W     = 32;                  // width of each count on the bus
    localparam int IN_TW    = 4 * IN_W;
    localparam int RATIO_W  = FRAC_BITS + 1;
    localparam int CORR_W   = FRAC_BITS + 2;
    localparam int USER_W   = 6;
    localparam int OUT_FW   = 5 * RATIO_W + CORR_W;
    localparam int OUT_TW   = ((OUT_FW + 7) / 8) * 8;

    localparam int SUM_W    = COUNT_BITS + 1;
    localparam int TOT_W    = COUNT_BITS + 2;

    // multiplier: both operands MW bits, B side taken MCHUNK bits per stage
    localparam int MW       = 2 * COUNT_BITS + 2;
    localparam int MCHUNK   = 16;
    localparam int MUL_LAT  = (MW + MCHUNK - 1) / MCHUNK;
    localparam int PRW      = 2 * MW;

    // ratio divider
    localparam int DW       = 2 * COUNT_BITS + 3;
    localparam int RW       = DW + FRAC_BITS + 1;
    localparam int DIV_LAT  = FRAC_BITS + 1;

    // correlation root search
    localparam int TW       = 4 * COUNT_BITS + 2 * FRAC_BITS + 7;
    localparam int DQW      = 4 * COUNT_BITS + FRAC_BITS + 5;

    typedef struct packed {
        logic mc;
        logic cc;
        logic sn;
        logic pr;
        logic f1;
        logic ed;
        logic neg;
    } t_flags;

endpackage

@@ sv/cmm_mul.sv @@
// Pipelined MW x MW unsigned multiplier, one MCHUNK-bit slice of B per stage.
// Depends on cmm_pkg. The pipeline advances only while i_en is high.
module cmm_mul (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [cmm_pkg::MW-1:0]  i_a,
    input  logic [cmm_pkg::MW-1:0]  i_b,
    output logic [cmm_pkg::PRW-1:0] o_p
);
    import cmm_pkg::*;

    localparam int BPW = MUL_LAT * MCHUNK;

    logic [MW-1:0]  r_a   [MUL_LAT];
    logic [BPW-1:0] r_b   [MUL_LAT];
    logic [PRW-1:0] r_acc [MUL_LAT];

    for (genvar k = 0; k < MUL_LAT; k++) begin : g_st
        logic [MW-1:0]        w_a;
        logic [BPW-1:0]       w_b;
        logic [PRW-1:0]       w_acc;
        logic [MW+MCHUNK-1:0] w_pp;
        logic [PRW-1:0]       n_acc;

        if (k == 0) begin : g_first
            assign w_a   = i_a;
            assign w_b   = BPW'(i_b);
            assign w_acc = '0;
        end else begin : g_next
            assign w_a   = r_a[k-1];
            assign w_b   = r_b[k-1];
            assign w_acc = r_acc[k-1];
        end

        assign w_pp  = w_a * w_b[k*MCHUNK +: MCHUNK];
        assign n_acc = w_acc + (PRW'(w_pp) << (k * MCHUNK));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]   <= w_a;
                r_b[k]   <= w_b;
                r_acc[k] <= n_acc;
            end
        end
    end

    assign o_p = r_acc[MUL_LAT-1];

endmodule

@@ sv/cmm_div.sv @@
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one quotient bit per stage.
// Depends on cmm_pkg. Requires num <= den; the pipeline advances only while i_en is high.
module cmm_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [cmm_pkg::DW-1:0]      i_num,
    input  logic [cmm_pkg::DW-1:0]      i_den,
    output logic [cmm_pkg::RATIO_W-1:0] o_quot
);
    import cmm_pkg::*;

    logic [RW-1:0]      r_rem [DIV_LAT];
    logic [DW-1:0]      r_den [DIV_LAT];
    logic [RATIO_W-1:0] r_q   [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_st
        localparam int B = FRAC_BITS - k;
        logic [RW-1:0]      w_rem;
        logic [DW-1:0]      w_den;
        logic [RATIO_W-1:0] w_q;
        logic [RW-1:0]      w_trial;
        logic               w_take;
        logic [RW-1:0]      n_rem;
        logic [RATIO_W-1:0] n_q;

        if (k == 0) begin : g_first
            assign w_rem = RW'(i_num) << FRAC_BITS;
            assign w_den = i_den;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_q   = r_q[k-1];
        end

        assign w_trial = RW'(w_den) << B;
        assign w_take  = (w_trial <= w_rem);
        assign n_rem   = w_take ? (w_rem - w_trial) : w_rem;
        assign n_q     = w_take ? (w_q | (RATIO_W'(1) << B)) : w_q;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den;
                r_q[k]   <= n_q;
            end
        end
    end

    assign o_quot = r_q[DIV_LAT-1];

endmodule

@@ sv/confusion_matrix_metrics.sv @@
// Confusion-matrix metrics top level: input staging, products, dividers, root search.
// Depends on cmm_pkg, cmm_mul, cmm_div and confusion_matrix_metrics_defines.svh.
//
// Usage:
//   Slave stream: one beat carries tp, fn, fp, tn (32 bits each, tp in the low bits).
//   Master stream: one beat per input beat, in order. tdata holds match_coeff,
//   corr_coeff, sensitivity, precision_val, f1_score, edit_dist (low to high);
//   tuser holds the six ok flags. A metric whose ok flag is low reads 0.
//   The pipeline is 30 stages plus the output register. Throughput is one beat per
//   cycle while the receiver does not stall; the stages are 2 input stages, two
//   5-stage multiplier passes with a difference stage between them, then 17
//   quotient-bit stages (one per bit of the dividers and of the correlation root
//   search).
//   The pipeline moves as one unit; a skid register behind the output register
//   lets one more beat drain while the receiver stalls, then s_axis_tready drops.
//   Nothing is lost or repeated under a stall.
//   Reset (synchronous, active low) empties the pipeline and both output slots;
//   the data registers themselves are not reset.
`include "confusion_matrix_metrics_defines.svh"

module confusion_matrix_metrics (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // true_pos, false_neg, false_pos, true_neg
    input  logic [cmm_pkg::IN_TW-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // match_coeff, corr_coeff, sensitivity, precision_val, f1_score, edit_dist, zero pad
    output logic [cmm_pkg::OUT_TW-1:0] m_axis_tdata,
    // match_ok, corr_ok, sens_ok, prec_ok, f1_ok, edit_ok
    output logic [cmm_pkg::USER_W-1:0] m_axis_tuser
);
    import cmm_pkg::*;

    localparam int CW     = COUNT_BITS;
    localparam int LAT    = 3 + 2 * MUL_LAT + DIV_LAT;
    localparam int FL_LAT = MUL_LAT + DIV_LAT;

    typedef struct packed {
        logic [DW-1:0] mc_n;
        logic [DW-1:0] mc_d;
        logic [DW-1:0] sn_n;
        logic [DW-1:0] sn_d;
        logic [DW-1:0] pr_n;
        logic [DW-1:0] pr_d;
        logic [DW-1:0] f1_n;
        logic [DW-1:0] f1_d;
        t_flags        fl;
    } t_rop;

    typedef struct packed {
        logic [RATIO_W-1:0] mc;
        logic [RATIO_W-1:0] sn;
        logic [RATIO_W-1:0] pr;
        logic [RATIO_W-1:0] f1;
        logic [RATIO_W-1:0] ed;
    } t_dq;

    logic w_en;
    logic [LAT-1:0] r_v;

    // output register with skid slot
    logic              r_out_v, r_skid_v;
    logic [OUT_TW-1:0] r_out_d, r_skid_d;
    logic [USER_W-1:0] r_out_u, r_skid_u;

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---- stage 1: counts -------------------------------------------------
    logic [CW-1:0] r1_tp, r1_fn, r1_fp, r1_tn;

    function automatic logic [CW-1:0] to_cnt(input logic [IN_W-1:0] f);
        logic [IN_W+CW-1:0] ext;
        ext = {{CW{1'b0}}, f};
        return ext[CW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_tp <= to_cnt(s_axis_tdata[0*IN_W +: IN_W]);
            r1_fn <= to_cnt(s_axis_tdata[1*IN_W +: IN_W]);
            r1_fp <= to_cnt(s_axis_tdata[2*IN_W +: IN_W]);
            r1_tn <= to_cnt(s_axis_tdata[3*IN_W +: IN_W]);
        end
    end

    // ---- stage 2: marginal sums and flags --------------------------------
    logic [CW-1:0]    r2_tp, r2_fn, r2_fp, r2_tn;
    logic [SUM_W-1:0] r2_spos, r2_sneg, r2_spp, r2_spn, r2_fnfp, r2_tptn, r2_tp2;
    logic [TOT_W-1:0] r2_tot, r2_f1d;
    t_flags           r2_fl;
    logic [SUM_W-1:0] n2_spos, n2_sneg, n2_spp, n2_spn;
    logic [TOT_W-1:0] n2_tot;
    t_flags           n2_fl;

    always_comb begin
        n2_spos   = SUM_W'(r1_tp) + SUM_W'(r1_fn);
        n2_sneg   = SUM_W'(r1_tn) + SUM_W'(r1_fp);
        n2_spp    = SUM_W'(r1_tp) + SUM_W'(r1_fp);
        n2_spn    = SUM_W'(r1_tn) + SUM_W'(r1_fn);
        n2_tot    = TOT_W'(n2_spos) + TOT_W'(n2_sneg);
        n2_fl.mc  = (n2_tot != '0);
        n2_fl.sn  = (n2_spos != '0);
        n2_fl.pr  = (n2_spp != '0);
        n2_fl.cc  = (n2_spos != '0) && (n2_sneg != '0) && (n2_spp != '0) && (n2_spn != '0);
        n2_fl.f1  = n2_fl.sn && n2_fl.pr && (r1_tp != '0);
        n2_fl.ed  = n2_fl.sn && n2_fl.pr;
        n2_fl.neg = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_tp   <= r1_tp;
            r2_fn   <= r1_fn;
            r2_fp   <= r1_fp;
            r2_tn   <= r1_tn;
            r2_spos <= n2_spos;
            r2_sneg <= n2_sneg;
            r2_spp  <= n2_spp;
            r2_spn  <= n2_spn;
            r2_fnfp <= SUM_W'(r1_fn) + SUM_W'(r1_fp);
            r2_tptn <= SUM_W'(r1_tp) + SUM_W'(r1_tn);
            r2_tp2  <= SUM_W'(r1_tp) << 1;
            r2_tot  <= n2_tot;
            r2_f1d  <= (TOT_W'(r1_tp) << 1) + TOT_W'(r1_fn) + TOT_W'(r1_fp);
            r2_fl   <= n2_fl;
        end
    end

    // ---- first product pass ---------------------------------------------
    logic [PRW-1:0] m_a, m_b, m_pa, m_pb, m_e1, m_e2;

    cmm_mul u_mul_a  (.i_clk, .i_en(w_en), .i_a(MW'(r2_tp)),   .i_b(MW'(r2_tn)),   .o_p(m_a));
    cmm_mul u_mul_b  (.i_clk, .i_en(w_en), .i_a(MW'(r2_fn)),   .i_b(MW'(r2_fp)),   .o_p(m_b));
    cmm_mul u_mul_pa (.i_clk, .i_en(w_en), .i_a(MW'(r2_spos)), .i_b(MW'(r2_sneg)), .o_p(m_pa));
    cmm_mul u_mul_pb (.i_clk, .i_en(w_en), .i_a(MW'(r2_spp)),  .i_b(MW'(r2_spn)),  .o_p(m_pb));
    cmm_mul u_mul_e1 (.i_clk, .i_en(w_en), .i_a(MW'(r2_tp)),   .i_b(MW'(r2_fnfp)), .o_p(m_e1));
    cmm_mul u_mul_e2 (.i_clk, .i_en(w_en), .i_a(MW'(r2_spos)), .i_b(MW'(r2_spp)),  .o_p(m_e2));

    // ratio operands ride alongside the multipliers
    t_rop w_rop;
    t_rop r_rop [MUL_LAT];

    always_comb begin
        w_rop.mc_n = DW'(r2_tptn);
        w_rop.mc_d = DW'(r2_tot);
        w_rop.sn_n = DW'(r2_tp);
        w_rop.sn_d = DW'(r2_spos);
        w_rop.pr_n = DW'(r2_tp);
        w_rop.pr_d = DW'(r2_spp);
        w_rop.f1_n = DW'(r2_tp2);
        w_rop.f1_d = DW'(r2_f1d);
        w_rop.fl   = r2_fl;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rop[0] <= w_rop;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_rop[k] <= r_rop[k-1];
            end
        end
    end

    // ---- stage 3: correlation difference, edit distance operands --------
    logic [2*CW-1:0] w_a, w_b, r3_mag;
    logic            w_neg;
    logic [MW-1:0]   r3_pa, r3_pb;
    logic [DW-1:0]   r3_edn, r3_edd;
    t_rop            r3_rop;
    t_rop            w3_rop;

    assign w_a   = m_a[2*CW-1:0];
    assign w_b   = m_b[2*CW-1:0];
    assign w_neg = (w_a < w_b);

    always_comb begin
        w3_rop        = r_rop[MUL_LAT-1];
        w3_rop.fl.neg = w_neg;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_mag <= w_neg ? (w_b - w_a) : (w_a - w_b);
            r3_pa  <= m_pa[MW-1:0];
            r3_pb  <= m_pb[MW-1:0];
            // tp*(fn+fp) + 2*fn*fp over 2*(tp+fn)*(tp+fp)
            r3_edn <= DW'(m_e1[2*CW:0]) + (DW'(w_b) << 1);
            r3_edd <= DW'(m_e2[MW-1:0]) << 1;
            r3_rop <= w3_rop;
        end
    end

    // ---- second product pass and dividers -------------------------------
    logic [PRW-1:0] m_sq, m_pd;

    cmm_mul u_mul_sq (.i_clk, .i_en(w_en), .i_a(MW'(r3_mag)), .i_b(MW'(r3_mag)), .o_p(m_sq));
    cmm_mul u_mul_pd (.i_clk, .i_en(w_en), .i_a(r3_pa),       .i_b(r3_pb),       .o_p(m_pd));

    t_dq w_dq;

    cmm_div u_div_mc (.i_clk, .i_en(w_en), .i_num(r3_rop.mc_n), .i_den(r3_rop.mc_d),
                      .o_quot(w_dq.mc));
    cmm_div u_div_sn (.i_clk, .i_en(w_en), .i_num(r3_rop.sn_n), .i_den(r3_rop.sn_d),
                      .o_quot(w_dq.sn));
    cmm_div u_div_pr (.i_clk, .i_en(w_en), .i_num(r3_rop.pr_n), .i_den(r3_rop.pr_d),
                      .o_quot(w_dq.pr));
    cmm_div u_div_f1 (.i_clk, .i_en(w_en), .i_num(r3_rop.f1_n), .i_den(r3_rop.f1_d),
                      .o_quot(w_dq.f1));
    cmm_div u_div_ed (.i_clk, .i_en(w_en), .i_num(r3_edn),      .i_den(r3_edd),
                      .o_quot(w_dq.ed));

    t_dq    r_dq [MUL_LAT];
    t_flags r_fd [FL_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dq[0] <= w_dq;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_dq[k] <= r_dq[k-1];
            end
            r_fd[0] <= r3_rop.fl;
            for (int k = 1; k < FL_LAT; k++) begin
                r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // ---- correlation root search: largest q with q^2 * P <= mag^2 * 2^2F ----
    // Keeps R = target - q^2*P and D = q*P so each bit needs only shifts and adds.
    logic [TW-1:0]      r_cr [DIV_LAT];
    logic [DQW-1:0]     r_cd [DIV_LAT];
    logic [PRW-1:0]     r_cp [DIV_LAT];
    logic [RATIO_W-1:0] r_cq [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_root
        localparam int B = FRAC_BITS - k;
        logic [TW-1:0]      w_r;
        logic [DQW-1:0]     w_d;
        logic [PRW-1:0]     w_p;
        logic [RATIO_W-1:0] w_q;
        logic [TW-1:0]      w_trial;
        logic               w_take;

        if (k == 0) begin : g_first
            assign w_r = TW'(m_sq) << (2 * FRAC_BITS);
            assign w_d = '0;
            assign w_p = m_pd;
            assign w_q = '0;
        end else begin : g_next
            assign w_r = r_cr[k-1];
            assign w_d = r_cd[k-1];
            assign w_p = r_cp[k-1];
            assign w_q = r_cq[k-1];
        end

        assign w_trial = (TW'(w_d) << (B + 1)) + (TW'(w_p) << (2 * B));
        // once q reaches 1.0 no lower bit may be added
        assign w_take  = !w_q[FRAC_BITS] && (w_trial <= w_r);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cr[k] <= w_take ? (w_r - w_trial) : w_r;
                r_cd[k] <= w_take ? (w_d + (DQW'(w_p) << B)) : w_d;
                r_cp[k] <= w_p;
                r_cq[k] <= w_take ? (w_q | (RATIO_W'(1) << B)) : w_q;
            end
        end
    end

    // ---- result formatting ----------------------------------------------
    t_flags             w_fl;
    t_dq                w_rq;
    logic [RATIO_W-1:0] w_root;
    logic [CORR_W-1:0]  w_corr;
    logic [OUT_TW-1:0]  w_ldata;
    logic [USER_W-1:0]  w_luser;
    logic               w_push;

    assign w_fl   = r_fd[FL_LAT-1];
    assign w_rq   = r_dq[MUL_LAT-1];
    assign w_root = r_cq[DIV_LAT-1];
    assign w_corr = !w_fl.cc ? '0 :
                    w_fl.neg ? (CORR_W'(0) - CORR_W'(w_root)) : CORR_W'(w_root);

    assign w_ldata = OUT_TW'({w_fl.ed ? w_rq.ed : RATIO_W'(0),
                              w_fl.f1 ? w_rq.f1 : RATIO_W'(0),
                              w_fl.pr ? w_rq.pr : RATIO_W'(0),
                              w_fl.sn ? w_rq.sn : RATIO_W'(0),
                              w_corr,
                              w_fl.mc ? w_rq.mc : RATIO_W'(0)});
    assign w_luser = {w_fl.ed, w_fl.f1, w_fl.pr, w_fl.sn, w_fl.cc, w_fl.mc};
    assign w_push  = w_en && r_v[LAT-1];

    // ---- output register with skid slot ---------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= w_push;
            end
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || m_axis_tready) begin
            r_out_d <= r_skid_v ? r_skid_d : w_ldata;
            r_out_u <= r_skid_v ? r_skid_u : w_luser;
        end else if (w_push) begin
            r_skid_d <= w_ldata;
            r_skid_u <= w_luser;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;
    assign m_axis_tuser  = r_out_u;

    // ---- checks ------------------------------------------------------------
    `CMM_ASSERT_SAME(a_skid_needs_out, r_skid_v, r_out_v, "skid slot full with output empty")
    `CMM_ASSERT_NEXT(a_stall_freezes, !w_en, $stable(r_v), "pipeline moved during a stall")
    `CMM_ASSERT_SAME(a_corr_zero_when_bad, m_axis_tvalid && !m_axis_tuser[1],
                     m_axis_tdata[RATIO_W +: CORR_W] == '0, "invalid correlation not zero")
    `CMM_ASSERT_SAME(a_edit_flag, m_axis_tvalid,
                     m_axis_tuser[5] == (m_axis_tuser[2] && m_axis_tuser[3]),
                     "edit flag disagrees with ratio flags")
    `CMM_ASSERT_SAME(a_f1_flag, m_axis_tvalid && m_axis_tuser[4], m_axis_tuser[5],
                     "f1 valid without edit valid")

endmodule
